// ----- src/chained_free_block_allocator_macros.svh -----
// assertion helpers for the allocator module
`ifndef CHAINED_FREE_BLOCK_ALLOCATOR_MACROS_SVH
`define CHAINED_FREE_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication on aclk, off during reset
`define CFBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on aclk, off during reset
`define CFBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cfba_pkg.sv -----
package cfba_pkg;

    localparam int unsigned CACHE_ENTRIES_DEF = 16;
    localparam int unsigned NUM_BLOCKS_DEF    = 256;

    localparam int unsigned BLK_W   = 8;
    localparam int unsigned ENTRY_W = 9;

    localparam logic [ENTRY_W-1:0] END_MARK = '1;

    localparam logic OP_ALLOC       = 1'b0;
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NOSPACE = 1'b1;

    typedef struct packed {
        logic             op;
        logic [BLK_W-1:0] block_in;
    } in_t;

    typedef struct packed {
        logic             status;
        logic [BLK_W-1:0] block_out;
    } out_t;

    // microcode addresses
    typedef enum logic [2:0] {
        U_DISPATCH,
        U_POP,
        U_PUSH,
        U_NOSPACE,
        U_REFILL,
        U_REFILL_END,
        U_SPILL,
        U_SPILL_END
    } upc_t;

    // datapath action per step
    typedef enum logic [2:0] {
        A_DISPATCH,
        A_POP_DONE,
        A_PUSH_DONE,
        A_NOSPACE_DONE,
        A_REFILL_STEP,
        A_REFILL_DONE,
        A_SPILL_STEP,
        A_SPILL_DONE
    } act_t;

    // sequencing: dispatch on new item, loop until last index, wait for output slot
    typedef enum logic [1:0] {
        J_DISPATCH,
        J_LOOP,
        J_WAIT
    } jmp_t;

    typedef struct packed {
        act_t act;
        jmp_t jmp;
        upc_t target;
    } ctrl_t;

    typedef struct packed {
        logic fire;
        upc_t entry;
        logic last;
        logic out_free;
    } seq_cond_t;

    function automatic ctrl_t ucode(upc_t addr);
        ctrl_t w;
        case (addr)
            U_DISPATCH:   w = '{act: A_DISPATCH,     jmp: J_DISPATCH, target: U_DISPATCH};
            U_POP:        w = '{act: A_POP_DONE,     jmp: J_WAIT,     target: U_DISPATCH};
            U_PUSH:       w = '{act: A_PUSH_DONE,    jmp: J_WAIT,     target: U_DISPATCH};
            U_NOSPACE:    w = '{act: A_NOSPACE_DONE, jmp: J_WAIT,     target: U_DISPATCH};
            U_REFILL:     w = '{act: A_REFILL_STEP,  jmp: J_LOOP,     target: U_REFILL_END};
            U_REFILL_END: w = '{act: A_REFILL_DONE,  jmp: J_WAIT,     target: U_DISPATCH};
            U_SPILL:      w = '{act: A_SPILL_STEP,   jmp: J_LOOP,     target: U_SPILL_END};
            U_SPILL_END:  w = '{act: A_SPILL_DONE,   jmp: J_WAIT,     target: U_DISPATCH};
            default:      w = '{act: A_DISPATCH,     jmp: J_DISPATCH, target: U_DISPATCH};
        endcase
        return w;
    endfunction

    // 9-bit value modulo a constant by shifted compare and subtract
    function automatic logic [ENTRY_W-1:0] mod9(logic [ENTRY_W-1:0] v, int unsigned m);
        logic [31:0] r;
        r = 32'(v);
        for (int k = ENTRY_W - 1; k >= 0; k--) begin
            if (r >= (32'(m) << k)) begin
                r = r - (32'(m) << k);
            end
        end
        return r[ENTRY_W-1:0];
    endfunction

endpackage

// ----- src/chained_free_block_allocator.sv -----
// push, pop and no-space items: accepted at dispatch, result written once the output slot is free
// refill and spill items: bound by copying one row entry per cycle
// through the single link store port
// a result waits in an output register; the next item is taken only after it is produced
// reset (aresetn low, synchronous): cache empty, link set to the end marker, output empty;
// the link store is not cleared and needs no clearing pass
`include "chained_free_block_allocator_macros.svh"

module chained_free_block_allocator
    import cfba_pkg::*;
#(
    parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    parameter int unsigned NUM_BLOCKS    = NUM_BLOCKS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int unsigned CNT_W    = $clog2(CACHE_ENTRIES);
    localparam int unsigned CAW      = (CACHE_ENTRIES > 2) ? $clog2(CACHE_ENTRIES - 1) : 1;
    localparam int unsigned ROW_W    = $clog2(NUM_BLOCKS);
    localparam int unsigned LS_DEPTH = NUM_BLOCKS * CACHE_ENTRIES;
    localparam int unsigned LS_AW    = $clog2(LS_DEPTH);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(CACHE_ENTRIES - 1);

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ENTRY_W-1:0] link_reg, link_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [BLK_W-1:0]   blk_reg, blk_next;
    logic [BLK_W-1:0]   res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    logic [ENTRY_W-1:0] cache_mem [CACHE_ENTRIES-1];
    logic               cache_rd_en;
    logic [CAW-1:0]     cache_raddr;
    logic [ENTRY_W-1:0] cache_rdata_reg;
    logic               cache_we;
    logic [CAW-1:0]     cache_waddr;
    logic [ENTRY_W-1:0] cache_wdata;

    logic [ENTRY_W-1:0] ls_mem [LS_DEPTH];
    logic               ls_rd_en;
    logic               ls_we;
    logic [CNT_W-1:0]   ls_idx;
    logic [LS_AW-1:0]   ls_addr;
    logic [ENTRY_W-1:0] ls_wdata;
    logic [ENTRY_W-1:0] ls_rdata_reg;

    ctrl_t              ctrl;
    seq_cond_t          cond;
    upc_t               entry;
    logic               s_fire;
    logic               out_free;
    logic               idx_last;
    logic [CNT_W-1:0]   cnt_dec;
    logic [CNT_W-1:0]   idx_dec;
    logic [ENTRY_W-1:0] row_src;
    logic [ENTRY_W-1:0] row_mod;

    cfba_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond    (cond),
        .ctrl    (ctrl)
    );

    assign s_ready  = (ctrl.act == A_DISPATCH);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign idx_last = (idx_reg == LAST_IDX);
    assign cnt_dec  = count_reg - CNT_W'(1);
    assign idx_dec  = idx_reg - CNT_W'(1);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign cond = '{fire: s_fire, entry: entry, last: idx_last, out_free: out_free};

    // pick the microcode routine for a new item
    always_comb begin
        if (s_data.op == OP_ALLOC) begin
            if (count_reg != '0) begin
                entry = U_POP;
            end else if (link_reg == END_MARK) begin
                entry = U_NOSPACE;
            end else begin
                entry = U_REFILL;
            end
        end else if (count_reg >= LAST_IDX) begin
            entry = U_SPILL;
        end else begin
            entry = U_PUSH;
        end
    end

    assign row_src = (entry == U_REFILL) ? link_reg : ENTRY_W'(s_data.block_in);
    assign row_mod = mod9(row_src, NUM_BLOCKS);
    assign ls_addr = LS_AW'(row_reg) * LS_AW'(CACHE_ENTRIES) + LS_AW'(ls_idx);

    always_comb begin
        count_next   = count_reg;
        link_next    = link_reg;
        idx_next     = idx_reg;
        row_next     = row_reg;
        blk_next     = blk_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        cache_rd_en  = 1'b0;
        cache_raddr  = idx_reg[CAW-1:0];
        cache_we     = 1'b0;
        cache_waddr  = count_reg[CAW-1:0];
        cache_wdata  = ENTRY_W'(blk_reg);
        ls_rd_en     = 1'b0;
        ls_we        = 1'b0;
        ls_idx       = idx_reg;
        ls_wdata     = cache_rdata_reg;
        case (ctrl.act)
            A_DISPATCH: begin
                if (s_fire) begin
                    blk_next = s_data.block_in;
                    res_next = link_reg[BLK_W-1:0];
                    row_next = ROW_W'(row_mod);
                    idx_next = '0;
                    if (entry == U_POP) begin
                        cache_rd_en = 1'b1;
                        cache_raddr = cnt_dec[CAW-1:0];
                    end
                end
            end
            A_POP_DONE: begin
                if (out_free) begin
                    count_next   = cnt_dec;
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: STATUS_OK,
                                     block_out: cache_rdata_reg[BLK_W-1:0]};
                end
            end
            A_PUSH_DONE: begin
                if (out_free) begin
                    cache_we     = 1'b1;
                    count_next   = count_reg + CNT_W'(1);
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: STATUS_OK, block_out: '0};
                end
            end
            A_NOSPACE_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: STATUS_NOSPACE, block_out: '0};
                end
            end
            A_REFILL_STEP: begin
                // read entry idx, write the previously read entry into the cache
                ls_rd_en = 1'b1;
                if (idx_reg != '0) begin
                    cache_we    = 1'b1;
                    cache_waddr = idx_dec[CAW-1:0];
                    cache_wdata = ls_rdata_reg;
                end
                if (!idx_last) begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            A_REFILL_DONE: begin
                if (out_free) begin
                    link_next    = ls_rdata_reg;
                    count_next   = LAST_IDX;
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: STATUS_OK, block_out: res_reg};
                end
            end
            A_SPILL_STEP: begin
                cache_rd_en = !idx_last;
                if (idx_reg != '0) begin
                    ls_we    = 1'b1;
                    ls_idx   = idx_dec;
                    ls_wdata = cache_rdata_reg;
                end
                if (!idx_last) begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            A_SPILL_DONE: begin
                if (out_free) begin
                    // link entry closes the row
                    ls_we        = 1'b1;
                    ls_idx       = LAST_IDX;
                    ls_wdata     = link_reg;
                    link_next    = ENTRY_W'(blk_reg);
                    count_next   = '0;
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: STATUS_OK, block_out: '0};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            link_reg    <= END_MARK;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            link_reg    <= link_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        row_reg    <= row_next;
        blk_reg    <= blk_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (cache_we) begin
            cache_mem[cache_waddr] <= cache_wdata;
        end
        if (cache_rd_en) begin
            cache_rdata_reg <= cache_mem[cache_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ls_we) begin
            ls_mem[ls_addr] <= ls_wdata;
        end
        if (ls_rd_en) begin
            ls_rdata_reg <= ls_mem[ls_addr];
        end
    end

    `CFBA_ASSERT_NXT(a_one_item, s_fire, !s_ready, "item taken while another is in progress")
    `CFBA_ASSERT_NXT(a_refill_full, (ctrl.act == A_REFILL_DONE) && out_free, count_reg == LAST_IDX, "refill did not leave a full cache")
    `CFBA_ASSERT_IMP(a_nospace_end, ctrl.act == A_NOSPACE_DONE, (link_reg == END_MARK) && (count_reg == '0), "no space reported with blocks left")
    `CFBA_ASSERT_IMP(a_cache_addr, cache_we, 32'(cache_waddr) < (CACHE_ENTRIES - 1), "cache write past last entry")

endmodule

// ----- src/cfba_seq.sv -----
module cfba_seq
    import cfba_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  seq_cond_t cond,
    output ctrl_t     ctrl
);

    upc_t upc_reg;
    upc_t upc_next;

    assign ctrl = ucode(upc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= U_DISPATCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

    always_comb begin
        upc_next = upc_reg;
        case (ctrl.jmp)
            J_DISPATCH: begin
                if (cond.fire) begin
                    upc_next = cond.entry;
                end
            end
            J_LOOP: begin
                if (cond.last) begin
                    upc_next = ctrl.target;
                end
            end
            J_WAIT: begin
                if (cond.out_free) begin
                    upc_next = ctrl.target;
                end
            end
            default: upc_next = U_DISPATCH;
        endcase
    end

endmodule
